[hw/rtl/ansi_pkg.sv]
// ansi_pkg: parser state codes, character constants and the result word type
// shared by the escape sequence parser and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ansi_pkg;

	typedef enum logic [2:0] {
		ST_PLAIN   = 3'd0,
		ST_ESC     = 3'd1,
		ST_CSI     = 3'd2,
		ST_OSC     = 3'd3,
		ST_OSC_ESC = 3'd4
	} ansi_state_t;

	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_BEL    = 8'h07;
	localparam logic [7:0] CH_CSI    = 8'h5B;
	localparam logic [7:0] CH_OSC    = 8'h5D;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] TWO_LO    = 8'h40;
	localparam logic [7:0] TWO_HI    = 8'h5F;
	localparam logic [7:0] CSI_LIMIT = 8'h40;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       keep;
		logic       end_of_text;
	} ansi_res_t;

endpackage

`default_nettype wire

[hw/rtl/ansi_parser.sv]
// ansi_parser: escape sequence state register and the per-byte keep/drop decision
// depends on ansi_pkg for state codes, character constants and the result word
`timescale 1ns / 1ps
`default_nettype none

module ansi_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        in_byte,
	input  wire logic              last,
	output ansi_pkg::ansi_res_t    res
);

	ansi_pkg::ansi_state_t state_q;
	ansi_pkg::ansi_state_t state_nxt;
	logic                  keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ansi_pkg::ST_PLAIN;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		keep      = 1'b0;
		case (state_q)
			ansi_pkg::ST_ESC: begin
				if (in_byte == ansi_pkg::CH_CSI) begin
					state_nxt = ansi_pkg::ST_CSI;
				end else if (in_byte == ansi_pkg::CH_OSC) begin
					state_nxt = ansi_pkg::ST_OSC;
				end else if (in_byte inside {[ansi_pkg::TWO_LO:ansi_pkg::TWO_HI]}) begin
					state_nxt = ansi_pkg::ST_PLAIN;
				end else if (in_byte == ansi_pkg::CH_ESC) begin
					// lone esc dropped, a second one opens a fresh escape
					state_nxt = ansi_pkg::ST_ESC;
				end else begin
					state_nxt = ansi_pkg::ST_PLAIN;
					keep      = 1'b1;
				end
			end
			ansi_pkg::ST_CSI: begin
				if (in_byte >= ansi_pkg::CSI_LIMIT) begin
					state_nxt = ansi_pkg::ST_PLAIN;
				end
			end
			ansi_pkg::ST_OSC, ansi_pkg::ST_OSC_ESC: begin
				if (state_q == ansi_pkg::ST_OSC_ESC && in_byte == ansi_pkg::CH_BSL) begin
					state_nxt = ansi_pkg::ST_PLAIN;
				end else if (in_byte == ansi_pkg::CH_BEL) begin
					state_nxt = ansi_pkg::ST_PLAIN;
				end else if (in_byte == ansi_pkg::CH_ESC) begin
					state_nxt = ansi_pkg::ST_OSC_ESC;
				end else begin
					state_nxt = ansi_pkg::ST_OSC;
				end
			end
			default: begin
				if (in_byte == ansi_pkg::CH_ESC) begin
					state_nxt = ansi_pkg::ST_ESC;
				end else begin
					state_nxt = ansi_pkg::ST_PLAIN;
					keep      = 1'b1;
				end
			end
		endcase
		// end of string always returns to plain text
		if (last) begin
			state_nxt = ansi_pkg::ST_PLAIN;
		end
	end

	assign res.out_byte    = keep ? in_byte : 8'h00;
	assign res.keep        = keep;
	assign res.end_of_text = last;

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (state_q == ansi_pkg::ST_PLAIN))
		else $error("parser not back in plain text after final byte");

	a_keep_only_text: assert property (@(posedge clk) disable iff (!arst_n)
		keep |-> (state_q != ansi_pkg::ST_CSI && state_q != ansi_pkg::ST_OSC &&
			state_q != ansi_pkg::ST_OSC_ESC))
		else $error("byte kept inside a csi or osc body");

	a_held_state: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(state_q))
		else $error("parser state moved without an accepted word");

endmodule

`default_nettype wire

[hw/rtl/ansi_escape_stripper.sv]
// ansi_escape_stripper: drops terminal escape sequences from a byte stream
// the result is registered in the output buffer; throughput one word per cycle while out_ready stays high
// a two-entry output buffer (result register plus skid) keeps input ready registered
// and lets a word in while an earlier result waits on out_ready
// reset: asynchronous, parser to plain text and output buffer empty
// depends on ansi_pkg and ansi_parser
`timescale 1ns / 1ps
`default_nettype none

module ansi_escape_stripper (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       last,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] out_byte,
	output      logic       keep,
	output      logic       end_of_text
);

	ansi_pkg::ansi_res_t res;
	ansi_pkg::ansi_res_t out_q;
	ansi_pkg::ansi_res_t skid_q;
	logic                out_valid_q;
	logic                skid_valid_q;
	logic                accept;
	logic                take;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;
	assign take     = out_valid_q && out_ready;

	ansi_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.last    (last),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= take ? (skid_valid_q || accept) : (out_valid_q || accept);
			if (accept && out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else if (take) begin
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q && take) begin
			out_q <= skid_q;
		end else if (accept && (!out_valid_q || take)) begin
			out_q <= res;
		end
		// word parks in the skid stage while the result register is stalled
		if (accept && out_valid_q && !take) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_q.out_byte;
	assign keep        = out_q.keep;
	assign end_of_text = out_q.end_of_text;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a word with the result register empty");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted word produced no result");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && take) |=> (out_valid_q && !skid_valid_q))
		else $error("skid word lost when result register drained");

endmodule

`default_nettype wire

[tb/ansi_escape_stripper_tb.sv]
// ansi_escape_stripper_tb: self-checking bench for the escape sequence stripper
// drives byte strings through the valid/ready input, predicts every result word and
// compares it with the block output; depends on ansi_pkg and the stripper rtl
`timescale 1ns / 1ps

module ansi_escape_stripper_tb;

	typedef struct packed {
		logic [7:0] b;
		logic       lst;
		logic       typed;
		logic       kp;
	} stim_t;

	// directed strings; typed rows carry their keep flag, the rest use the predictor
	localparam stim_t ROWS [0:25] = '{
		'{8'h41,               1'b0, 1'b1, 1'b1},
		'{8'hFF,               1'b0, 1'b1, 1'b1},
		'{8'h01,               1'b1, 1'b1, 1'b1},
		'{ansi_pkg::CH_ESC,    1'b0, 1'b1, 1'b0},
		'{ansi_pkg::CH_CSI,    1'b0, 1'b0, 1'b0},
		'{8'h3F,               1'b0, 1'b0, 1'b0},
		'{ansi_pkg::CSI_LIMIT, 1'b0, 1'b0, 1'b0},
		'{ansi_pkg::CH_ESC,    1'b0, 1'b1, 1'b0},
		'{ansi_pkg::CH_OSC,    1'b0, 1'b0, 1'b0},
		'{8'h78,               1'b0, 1'b0, 1'b0},
		'{ansi_pkg::CH_ESC,    1'b0, 1'b0, 1'b0},
		'{8'h71,               1'b0, 1'b0, 1'b0},
		'{ansi_pkg::CH_BEL,    1'b0, 1'b0, 1'b0},
		'{ansi_pkg::CH_ESC,    1'b0, 1'b1, 1'b0},
		'{ansi_pkg::CH_OSC,    1'b0, 1'b0, 1'b0},
		'{ansi_pkg::CH_ESC,    1'b0, 1'b0, 1'b0},
		'{ansi_pkg::CH_BSL,    1'b0, 1'b0, 1'b0},
		'{ansi_pkg::CH_ESC,    1'b0, 1'b1, 1'b0},
		'{ansi_pkg::TWO_HI,    1'b0, 1'b0, 1'b0},
		'{ansi_pkg::CH_ESC,    1'b0, 1'b1, 1'b0},
		'{8'h61,               1'b0, 1'b0, 1'b0},
		'{ansi_pkg::CH_ESC,    1'b0, 1'b1, 1'b0},
		'{ansi_pkg::CH_ESC,    1'b0, 1'b0, 1'b0},
		'{ansi_pkg::CH_CSI,    1'b0, 1'b0, 1'b0},
		'{8'h35,               1'b1, 1'b0, 1'b0},
		'{8'h7A,               1'b0, 1'b1, 1'b1}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       keep;
	logic       end_of_text;

	stim_t                 byte_stream [$];
	ansi_pkg::ansi_res_t   expected_words [$];
	ansi_pkg::ansi_state_t strip_state = ansi_pkg::ST_PLAIN;
	int                    n_fail = 0;
	int                    n_words = 0;
	int                    n_kept = 0;
	int                    n_strings = 0;

	ansi_escape_stripper DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.keep(keep),
		.end_of_text(end_of_text)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// advances the parser state by one byte and returns the word it gives
	function automatic ansi_pkg::ansi_res_t strip_next(logic [7:0] b, logic lst);
		ansi_pkg::ansi_res_t r;
		logic                kp;
		kp = 1'b0;
		case (strip_state)
			ansi_pkg::ST_ESC: begin
				if (b == ansi_pkg::CH_CSI)
					strip_state = ansi_pkg::ST_CSI;
				else if (b == ansi_pkg::CH_OSC)
					strip_state = ansi_pkg::ST_OSC;
				else if (b >= ansi_pkg::TWO_LO && b <= ansi_pkg::TWO_HI)
					strip_state = ansi_pkg::ST_PLAIN;
				else if (b == ansi_pkg::CH_ESC)
					strip_state = ansi_pkg::ST_ESC;
				else begin
					strip_state = ansi_pkg::ST_PLAIN;
					kp = 1'b1;
				end
			end
			ansi_pkg::ST_CSI: begin
				if (b >= ansi_pkg::CSI_LIMIT)
					strip_state = ansi_pkg::ST_PLAIN;
			end
			ansi_pkg::ST_OSC, ansi_pkg::ST_OSC_ESC: begin
				if (strip_state == ansi_pkg::ST_OSC_ESC && b == ansi_pkg::CH_BSL)
					strip_state = ansi_pkg::ST_PLAIN;
				else if (b == ansi_pkg::CH_BEL)
					strip_state = ansi_pkg::ST_PLAIN;
				else if (b == ansi_pkg::CH_ESC)
					strip_state = ansi_pkg::ST_OSC_ESC;
				else
					strip_state = ansi_pkg::ST_OSC;
			end
			default: begin
				if (b == ansi_pkg::CH_ESC)
					strip_state = ansi_pkg::ST_ESC;
				else
					kp = 1'b1;
			end
		endcase
		if (lst)
			strip_state = ansi_pkg::ST_PLAIN;
		r.out_byte = kp ? b : 8'h00;
		r.keep = kp;
		r.end_of_text = lst;
		return r;
	endfunction

	// printable-ish text byte, never an escape
	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		if (c == ansi_pkg::CH_ESC)
			c = 8'h65;
		return c;
	endfunction

	// osc body byte that neither terminates nor starts a terminator
	function automatic logic [7:0] osc_body();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		if (c == ansi_pkg::CH_BEL || c == ansi_pkg::CH_ESC)
			c = 8'h2E;
		return c;
	endfunction

	// one string of random segments, mostly well-formed, sometimes cut short
	task automatic add_string();
		logic [7:0] s [$];
		logic [7:0] c;
		int         kind;
		int         cut;
		stim_t      row;
		repeat ($urandom_range(1, 6)) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				repeat ($urandom_range(1, 8))
					s.push_back(text_byte());
			end else if (kind < 50) begin
				s.push_back(ansi_pkg::CH_ESC);
				s.push_back(ansi_pkg::CH_CSI);
				repeat ($urandom_range(0, 4))
					s.push_back(8'($urandom_range(1, 8'h3F)));
				s.push_back(8'($urandom_range(8'h40, 255)));
			end else if (kind < 68) begin
				s.push_back(ansi_pkg::CH_ESC);
				s.push_back(ansi_pkg::CH_OSC);
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 4) == 0) begin
						// stray escape inside the body
						c = osc_body();
						if (c == ansi_pkg::CH_BSL)
							c = 8'h5E;
						s.push_back(ansi_pkg::CH_ESC);
						s.push_back(c);
					end else
						s.push_back(osc_body());
				end
				if ($urandom_range(0, 1)) begin
					s.push_back(ansi_pkg::CH_BEL);
				end else begin
					s.push_back(ansi_pkg::CH_ESC);
					s.push_back(ansi_pkg::CH_BSL);
				end
			end else if (kind < 80) begin
				s.push_back(ansi_pkg::CH_ESC);
				s.push_back(8'($urandom_range(ansi_pkg::TWO_LO, ansi_pkg::TWO_HI)));
			end else if (kind < 88) begin
				c = 8'($urandom_range(1, 255));
				if (c >= ansi_pkg::TWO_LO && c <= ansi_pkg::TWO_HI)
					c = c ^ 8'h20;
				s.push_back(ansi_pkg::CH_ESC);
				s.push_back(c);
			end else begin
				repeat ($urandom_range(1, 6))
					s.push_back(8'($urandom_range(1, 255)));
			end
		end
		if ($urandom_range(0, 6) == 0) begin
			cut = $urandom_range(1, s.size());
			while (s.size() > cut)
				void'(s.pop_back());
		end
		foreach (s[k]) begin
			row.b = s[k];
			row.lst = (k == s.size() - 1);
			row.typed = 1'b0;
			row.kp = 1'b0;
			byte_stream.push_back(row);
		end
	endtask

	initial begin : sender
		stim_t               row;
		ansi_pkg::ansi_res_t want;
		int                  gap;
		int                  n_sent;
		n_sent = 0;
		foreach (ROWS[k])
			byte_stream.push_back(ROWS[k]);
		while (byte_stream.size() < $size(ROWS) + 700)
			add_string();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (byte_stream.size() > 0) begin
			row = byte_stream.pop_front();
			gap = ((n_sent / 50) % 3 == 2) ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte <= row.b;
			last <= row.lst;
			do @(posedge clk); while (!in_ready);
			want = strip_next(row.b, row.lst);
			if (row.typed) begin
				want.out_byte = row.kp ? row.b : 8'h00;
				want.keep = row.kp;
				want.end_of_text = row.lst;
			end
			expected_words.push_back(want);
			n_sent++;
		end
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("sent %0d bytes in %0d strings, checked %0d words, %0d kept as text",
			n_sent, n_strings, n_words, n_kept);
		$display("directed escapes plus random csi, osc, two-byte and cut-off strings");
		if (n_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin : receiver
		int stall;
		int n_taken;
		n_taken = 0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			// one long hold-off so the output buffer fills and input ready drops
			if (n_taken == 250)
				stall = 240;
			else if ((n_taken / 60) % 3 == 1)
				stall = 0;
			else
				stall = $urandom_range(0, 19);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			n_taken++;
		end
	end

	always @(posedge clk) begin : result_check
		ansi_pkg::ansi_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$display("%0t: word with nothing expected: byte %02h keep %b end %b",
					$time, out_byte, keep, end_of_text);
				n_fail++;
			end else begin
				want = expected_words.pop_front();
				if (keep !== want.keep) begin
					$display("%0t: keep expected %b got %b", $time, want.keep, keep);
					n_fail++;
				end
				// the byte only carries meaning on kept words
				if (want.keep && out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %02h got %02h",
						$time, want.out_byte, out_byte);
					n_fail++;
				end
				if (end_of_text !== want.end_of_text) begin
					$display("%0t: end_of_text expected %b got %b",
						$time, want.end_of_text, end_of_text);
					n_fail++;
				end
				n_words++;
				if (want.keep)
					n_kept++;
				if (want.end_of_text)
					n_strings++;
			end
		end
	end

	initial begin : watchdog
		#500000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ansi_pkg.sv
hw/rtl/ansi_parser.sv
hw/rtl/ansi_escape_stripper.sv
tb/ansi_escape_stripper_tb.sv
